/* rtl/spbg_pkg.sv */
`default_nettype none

package spbg_pkg;

    localparam int MAX_SLOT_BITS = 6;
    localparam int BITS_W        = 3;
    localparam int SLOT_W        = MAX_SLOT_BITS;
    localparam int STEP_W        = MAX_SLOT_BITS + 1;
    localparam int CHAN_N        = 6;
    localparam int COL_W         = 6;
    localparam int ROW_W         = 4;
    localparam int VAL_W         = 8;
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;
    localparam int SCALE_W       = VAL_W + MAX_SLOT_BITS + 1;

    localparam logic [BITS_W-1:0] SLOT_BITS_RESET = BITS_W'(4);
    localparam logic [BITS_W-1:0] SLOT_BITS_MAX   = BITS_W'(MAX_SLOT_BITS);
    localparam logic [ADDR_W-3:0] REG_SLOT_BITS   = '0;

    typedef logic [STEP_W-1:0] step_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_index;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic [CHAN_N-1:0] lit_bits;
        logic              bank;
        logic              last_slot;
    } result_t;

    // on-count of a channel: round(v * 2^b / 255)
    function automatic step_t pwm_steps(input logic [VAL_W-1:0] v,
                                        input logic [BITS_W-1:0] b);
        logic [SCALE_W-1:0] n;
        logic [SCALE_W:0]   q;
        n = (SCALE_W'(v) << b) + SCALE_W'(127);
        q = (SCALE_W+1)'(n) + (SCALE_W+1)'(n >> 8) + (SCALE_W+1)'(1);
        return STEP_W'(q >> 8);
    endfunction

    // binary-tree scrambled rank of a slot
    function automatic logic [SLOT_W-1:0] slot_rank(input logic [SLOT_W-1:0] s,
                                                    input logic [BITS_W-1:0] b);
        logic [BITS_W-1:0] t;
        logic [SLOT_W-1:0] half;
        logic [SLOT_W:0]   top;
        logic [BITS_W-1:0] sh;
        t    = '0;
        half = '0;
        top  = '0;
        sh   = '0;
        for (int i = SLOT_W - 1; i >= 0; i--)
        begin
            if (s[i])
            begin
                t = BITS_W'(i);
            end
        end
        if (b == '0)
        begin
            return '0;
        end
        half = SLOT_W'((SLOT_W+1)'(1) << (b - BITS_W'(1)));
        if (s == half)
        begin
            return '0;
        end
        if (s == '0)
        begin
            return SLOT_W'(1);
        end
        sh  = b - BITS_W'(1) - t;
        top = (SLOT_W+1)'(1) << sh;
        return SLOT_W'(top + (SLOT_W+1)'(s >> (t + BITS_W'(1))));
    endfunction

endpackage

`default_nettype wire

/* rtl/spbg_cfg.sv */
`default_nettype none

module spbg_cfg
    import spbg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output logic      [BITS_W-1:0] eff_bits
);

    logic [BITS_W-1:0] slot_bits_reg;
    logic [BITS_W-1:0] slot_bits_next;
    logic              sel_slot_bits;

    assign pready        = 1'b1;
    assign sel_slot_bits = (paddr[ADDR_W-1:2] == REG_SLOT_BITS);

    always_comb
    begin
        slot_bits_next = slot_bits_reg;
        if (psel && penable && pwrite && sel_slot_bits)
        begin
            slot_bits_next = pwdata[BITS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_bits_reg <= SLOT_BITS_RESET;
        end
        else
        begin
            slot_bits_reg <= slot_bits_next;
        end
    end

    assign prdata   = sel_slot_bits ? DATA_W'(slot_bits_reg) : '0;
    // values above the maximum saturate
    assign eff_bits = (slot_bits_reg > SLOT_BITS_MAX) ? SLOT_BITS_MAX : slot_bits_reg;

endmodule

`default_nettype wire

/* rtl/spbg_slot_gen.sv */
`default_nettype none

module spbg_slot_gen
    import spbg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [BITS_W-1:0] eff_bits,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [COL_W-1:0]  column,
    input  wire logic [ROW_W-1:0]  row,
    input  wire logic [VAL_W-1:0]  red_upper,
    input  wire logic [VAL_W-1:0]  green_upper,
    input  wire logic [VAL_W-1:0]  blue_upper,
    input  wire logic [VAL_W-1:0]  red_lower,
    input  wire logic [VAL_W-1:0]  green_lower,
    input  wire logic [VAL_W-1:0]  blue_lower,
    input  wire logic              frame_end,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output result_t                res
);

    logic              item_valid_reg;
    logic              item_valid_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic              frame_bank_reg;
    logic              frame_bank_next;
    logic [BITS_W-1:0] bits_reg;
    logic [COL_W-1:0]  column_reg;
    logic [ROW_W-1:0]  row_reg;
    logic              bank_reg;
    step_t             steps_reg [CHAN_N];

    logic              accept;
    logic              advance;
    logic              last;
    logic              done;
    logic [SLOT_W-1:0] slot_mask;
    logic [SLOT_W-1:0] rank;
    logic [VAL_W-1:0]  chan_val [CHAN_N];

    assign chan_val[0] = red_upper;
    assign chan_val[1] = green_upper;
    assign chan_val[2] = blue_upper;
    assign chan_val[3] = red_lower;
    assign chan_val[4] = green_lower;
    assign chan_val[5] = blue_lower;

    assign slot_mask = SLOT_W'(((SLOT_W+1)'(1) << bits_reg) - (SLOT_W+1)'(1));
    assign last      = (slot_reg == slot_mask);
    assign advance   = item_valid_reg && res_ready;
    assign done      = advance && last;
    assign in_stall  = item_valid_reg && !done;
    assign accept    = in_valid && !in_stall;
    assign rank      = slot_rank(slot_reg, bits_reg);

    always_comb
    begin
        item_valid_next = item_valid_reg;
        slot_next       = slot_reg;
        frame_bank_next = frame_bank_reg;
        if (accept)
        begin
            item_valid_next = 1'b1;
            slot_next       = '0;
            frame_bank_next = frame_bank_reg ^ frame_end;
        end
        else if (done)
        begin
            item_valid_next = 1'b0;
        end
        else if (advance)
        begin
            slot_next = slot_reg + SLOT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            slot_reg       <= '0;
            frame_bank_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            slot_reg       <= slot_next;
            frame_bank_reg <= frame_bank_next;
        end
    end

    // request payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bits_reg   <= eff_bits;
            column_reg <= column;
            row_reg    <= row;
            bank_reg   <= frame_bank_reg;
            for (int c = 0; c < CHAN_N; c++)
            begin
                steps_reg[c] <= pwm_steps(chan_val[c], eff_bits);
            end
        end
    end

    assign res_valid = item_valid_reg;

    always_comb
    begin
        res.slot_index = slot_reg;
        res.column     = column_reg;
        res.row        = row_reg;
        res.bank       = bank_reg;
        res.last_slot  = last;
        for (int c = 0; c < CHAN_N; c++)
        begin
            res.lit_bits[c] = (STEP_W'(rank) < steps_reg[c]);
        end
    end

    slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg |-> ((slot_reg & ~slot_mask) == '0))
        else $error("slot counter beyond slot count");

    slot_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && res_ready && !last)
            |=> (item_valid_reg && slot_reg == $past(slot_reg) + SLOT_W'(1)))
        else $error("slot counter did not step");

    slot_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && !res_ready) |=> (item_valid_reg && $stable(slot_reg)))
        else $error("slot moved while result blocked");

endmodule

`default_nettype wire

/* rtl/spbg_out_reg.sv */
`default_nettype none

module spbg_out_reg
    import spbg_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    res_valid,
    output logic         res_ready,
    input  wire result_t res,
    output logic         out_valid,
    input  wire logic    out_stall,
    output result_t      out_res
);

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_res_reg;

    assign res_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

`default_nettype wire

/* rtl/scrambled_pwm_bitplane_gen.sv */
// scrambled pwm bitplane generator for a two-half led panel
// input channel: in_valid / in_stall, one pixel pair per request
// (column, row, upper and lower rgb, frame_end)
// output channel: out_valid / out_stall, one request per pwm slot
// each pixel pair yields 2^b slot requests in ascending slot order,
// b = slot_bits register (saturated at 6), last_slot marks the final one
// a slot lights a channel when its tree-scrambled rank is below
// round(v * 2^b / 255)
// a taken pixel pair is registered in the slot generator, and each slot
// then in the output register; throughput: one slot per cycle while
// out_stall is low, set by the single slot counter
// the next pixel pair is taken in the cycle its predecessor's last slot
// moves to the output register; slot_bits is written over the apb port
// at byte address 0, by the user only while idle, unenforced by the block
// reset: no requests pending, slot_bits = 4, frame bank = 0
// bank toggles for the pixel pair after one flagged frame_end
// an output stall holds the current slot; the input stalls once the
// slot counter is busy
`default_nettype none

module scrambled_pwm_bitplane_gen
    import spbg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [COL_W-1:0]  column,
    input  wire logic [ROW_W-1:0]  row,
    input  wire logic [VAL_W-1:0]  red_upper,
    input  wire logic [VAL_W-1:0]  green_upper,
    input  wire logic [VAL_W-1:0]  blue_upper,
    input  wire logic [VAL_W-1:0]  red_lower,
    input  wire logic [VAL_W-1:0]  green_lower,
    input  wire logic [VAL_W-1:0]  blue_lower,
    input  wire logic              frame_end,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic      [SLOT_W-1:0] slot_index,
    output logic      [COL_W-1:0]  out_column,
    output logic      [ROW_W-1:0]  out_row,
    output logic      [CHAN_N-1:0] lit_bits,
    output logic                   out_bank,
    output logic                   last_slot
);

    logic [BITS_W-1:0] eff_bits;
    logic              res_valid;
    logic              res_ready;
    result_t           res;
    result_t           out_res;

    spbg_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .eff_bits (eff_bits)
    );

    spbg_slot_gen u_slot_gen (
        .clk         (clk),
        .rst_n       (rst_n),
        .eff_bits    (eff_bits),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .column      (column),
        .row         (row),
        .red_upper   (red_upper),
        .green_upper (green_upper),
        .blue_upper  (blue_upper),
        .red_lower   (red_lower),
        .green_lower (green_lower),
        .blue_lower  (blue_lower),
        .frame_end   (frame_end),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    spbg_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign slot_index = out_res.slot_index;
    assign out_column = out_res.column;
    assign out_row    = out_res.row;
    assign lit_bits   = out_res.lit_bits;
    assign out_bank   = out_res.bank;
    assign last_slot  = out_res.last_slot;

endmodule

`default_nettype wire
